// File: sv/psra_pkg.sv
// Package for the PID step core: shared widths, register and opcode codes,
// micro-instruction format and the microcode program itself.
// No dependencies.
`default_nettype none

package psra_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REG_WIDTH       = 31;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int OPCODE_WIDTH    = 2;
   localparam int PC_WIDTH        = 5;
   localparam int MUL_CHUNK       = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP          = 3'd0,
      CSR_KI_HALF_TS  = 3'd1,
      CSR_KD_OVER_TS  = 3'd2,
      CSR_INV_KP      = 3'd3,
      CSR_LIMIT       = 3'd4,
      CSR_RAMP_STEP   = 3'd5,
      CSR_ANTI_WINDUP = 3'd6
   } csr_index_type;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OPC_STEP      = 2'd0,
      OPC_CLEAR_ALL = 2'd1,
      OPC_CLEAR_INT = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      UOP_MUL, UOP_ADD, UOP_CLAMP, UOP_RAMP, UOP_JNAW, UOP_FIN
   } uop_type;

   typedef enum logic [3:0] {
      SRC_ZERO, SRC_ERR, SRC_PERR, SRC_INTEG, SRC_P, SRC_I, SRC_D, SRC_S, SRC_Y
   } src_type;

   typedef enum logic [2:0] {
      DST_P, DST_I, DST_D, DST_S, DST_Y
   } dst_type;

   typedef enum logic [1:0] {
      GAIN_KP, GAIN_KI, GAIN_KD, GAIN_INV_KP
   } gain_type;

   typedef enum logic [1:0] {
      FIN_STEP, FIN_CLEAR_ALL, FIN_CLEAR_INT, FIN_NONE
   } fin_type;

   typedef struct packed {
      uop_type               uop;
      src_type               src_a;
      src_type               src_b;
      logic                  neg_b;
      gain_type              gain;
      dst_type               dst;
      fin_type               fin;
      logic [PC_WIDTH-1:0]   target;
   } ucode_type;

   typedef struct packed {
      ucode_type cw;
      logic      exec;
      logic      mul_start;
      logic      mul_wr;
      logic      fin;
   } psra_ctrl_type;

   localparam logic [PC_WIDTH-1:0] UA_STEP      = 5'd0;
   localparam logic [PC_WIDTH-1:0] UA_LIMITS    = 5'd10;
   localparam logic [PC_WIDTH-1:0] UA_CLEAR_ALL = 5'd16;
   localparam logic [PC_WIDTH-1:0] UA_CLEAR_INT = 5'd17;
   localparam logic [PC_WIDTH-1:0] UA_IGNORE    = 5'd18;

   function automatic ucode_type uword(input uop_type uop, input src_type a,
                                       input src_type b, input logic neg,
                                       input gain_type g, input dst_type d,
                                       input fin_type f,
                                       input logic [PC_WIDTH-1:0] tgt);
      ucode_type w;
      w.uop    = uop;
      w.src_a  = a;
      w.src_b  = b;
      w.neg_b  = neg;
      w.gain   = g;
      w.dst    = d;
      w.fin    = f;
      w.target = tgt;
      return w;
   endfunction

   // The control program. Each word drives one step of the datapath.
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] addr);
      ucode_type w;
      case (addr)
         // proportional term, trapezoid integral, derivative term
         UA_STEP: w = uword(UOP_MUL, SRC_ERR, SRC_ZERO, 1'b0, GAIN_KP, DST_P,
                            FIN_NONE, UA_STEP);
         5'd1:  w = uword(UOP_MUL, SRC_ERR, SRC_PERR, 1'b0, GAIN_KI, DST_I,
                          FIN_NONE, UA_STEP);
         5'd2:  w = uword(UOP_ADD, SRC_INTEG, SRC_I, 1'b0, GAIN_KP, DST_I,
                          FIN_NONE, UA_STEP);
         5'd3:  w = uword(UOP_MUL, SRC_ERR, SRC_PERR, 1'b1, GAIN_KD, DST_D,
                          FIN_NONE, UA_STEP);
         5'd4:  w = uword(UOP_JNAW, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_KP, DST_P,
                          FIN_NONE, UA_LIMITS);
         // back-calculation: feed the clamp excess back into the integral
         5'd5:  w = uword(UOP_ADD, SRC_P, SRC_I, 1'b0, GAIN_KP, DST_S,
                          FIN_NONE, UA_STEP);
         5'd6:  w = uword(UOP_ADD, SRC_S, SRC_D, 1'b0, GAIN_KP, DST_S,
                          FIN_NONE, UA_STEP);
         5'd7:  w = uword(UOP_CLAMP, SRC_S, SRC_ZERO, 1'b0, GAIN_KP, DST_Y,
                          FIN_NONE, UA_STEP);
         5'd8:  w = uword(UOP_MUL, SRC_Y, SRC_S, 1'b1, GAIN_INV_KP, DST_S,
                          FIN_NONE, UA_STEP);
         5'd9:  w = uword(UOP_ADD, SRC_I, SRC_S, 1'b0, GAIN_KP, DST_I,
                          FIN_NONE, UA_STEP);
         // clamp integral, sum, clamp output, ramp, retire
         UA_LIMITS: w = uword(UOP_CLAMP, SRC_I, SRC_ZERO, 1'b0, GAIN_KP, DST_I,
                              FIN_NONE, UA_STEP);
         5'd11: w = uword(UOP_ADD, SRC_P, SRC_I, 1'b0, GAIN_KP, DST_Y,
                          FIN_NONE, UA_STEP);
         5'd12: w = uword(UOP_ADD, SRC_Y, SRC_D, 1'b0, GAIN_KP, DST_Y,
                          FIN_NONE, UA_STEP);
         5'd13: w = uword(UOP_CLAMP, SRC_Y, SRC_ZERO, 1'b0, GAIN_KP, DST_Y,
                          FIN_NONE, UA_STEP);
         5'd14: w = uword(UOP_RAMP, SRC_Y, SRC_ZERO, 1'b0, GAIN_KP, DST_Y,
                          FIN_NONE, UA_STEP);
         5'd15: w = uword(UOP_FIN, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_KP, DST_Y,
                          FIN_STEP, UA_STEP);
         UA_CLEAR_ALL: w = uword(UOP_FIN, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_KP,
                                 DST_Y, FIN_CLEAR_ALL, UA_STEP);
         UA_CLEAR_INT: w = uword(UOP_FIN, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_KP,
                                 DST_Y, FIN_CLEAR_INT, UA_STEP);
         default: w = uword(UOP_FIN, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_KP, DST_Y,
                            FIN_NONE, UA_STEP);
      endcase
      return w;
   endfunction

   function automatic logic [PC_WIDTH-1:0] entry_addr(
      input logic [OPCODE_WIDTH-1:0] opcode);
      logic [PC_WIDTH-1:0] a;
      case (opcode)
         OPC_STEP:      a = UA_STEP;
         OPC_CLEAR_ALL: a = UA_CLEAR_ALL;
         OPC_CLEAR_INT: a = UA_CLEAR_INT;
         default:       a = UA_IGNORE;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// File: sv/psra_mul.sv
// Shared sequential multiplier: signed operand times unsigned Q15.16 gain,
// truncated toward zero and saturated. Built from 32-bit partial products.
// Depends on psra_pkg.
`default_nettype none

module psra_mul import psra_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DATA_WIDTH+1:0] operand,
   input  wire logic [REG_WIDTH-1:0]         gain,
   output logic                              done,
   output logic signed [DATA_WIDTH-1:0]      result
);

   localparam int SW    = DATA_WIDTH + 2;
   localparam int MW    = DATA_WIDTH + 1;
   localparam int NCH   = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int MPW   = NCH * MUL_CHUNK;
   localparam int PW    = MPW + REG_WIDTH;
   localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
   localparam logic [PW-1:0] SMAX_P = PW'({(DATA_WIDTH-1){1'b1}});

   typedef enum logic [1:0] {MUL_IDLE, MUL_ACC, MUL_SAT} mul_state_type;

   mul_state_type                  state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic [MPW-1:0]                 mag_ff, mag_in;
   logic [REG_WIDTH-1:0]           gain_ff, gain_in;
   logic [PW-1:0]                  acc_ff, acc_in;
   logic                           done_ff, done_in;
   logic signed [DATA_WIDTH-1:0]   res_ff, res_in;

   logic [SW-1:0]                  op_mag;
   logic [MUL_CHUNK+REG_WIDTH-1:0] prod;
   logic [PW-1:0]                  shifted;
   logic signed [DATA_WIDTH-1:0]   mag_sat;

   always_comb begin
      op_mag  = operand[SW-1] ? SW'(-operand) : SW'(operand);
      prod    = mag_ff[MPW-1 -: MUL_CHUNK] * gain_ff;
      shifted = acc_ff >> FRAC_BITS;
      mag_sat = (shifted > SMAX_P) ? SMAX_P[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      gain_in  = gain_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               neg_in   = operand[SW-1];
               mag_in   = MPW'(op_mag[MW-1:0]);
               gain_in  = gain;
               acc_in   = '0;
               cnt_in   = CNT_W'(NCH - 1);
               state_in = MUL_ACC;
            end
         end
         MUL_ACC: begin
            // most significant chunk first, so the sum only ever shifts left
            acc_in = (acc_ff << MUL_CHUNK) + PW'(prod);
            mag_in = mag_ff << MUL_CHUNK;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = MUL_SAT;
            end
         end
         MUL_SAT: begin
            res_in   = neg_ff ? -mag_sat : mag_sat;
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
         default: state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      gain_ff <= gain_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// File: sv/psra_seq.sv
// Microcode sequencer: step counter, program fetch, conditional jump and
// handshake with the shared multiplier and the output register.
// Depends on psra_pkg.
`default_nettype none

module psra_seq import psra_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [OPCODE_WIDTH-1:0] opcode,
   input  wire logic                    aw_enable,
   input  wire logic                    mul_done,
   input  wire logic                    out_free,
   output logic                         idle,
   output psra_ctrl_type                ctrl
);

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_RUN, SEQ_WAIT} seq_state_type;

   seq_state_type       state_ff, state_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   ucode_type           cw;

   always_comb begin
      cw             = ucode_rom(pc_ff);
      state_in       = state_ff;
      pc_in          = pc_ff;
      ctrl.cw        = cw;
      ctrl.exec      = 1'b0;
      ctrl.mul_start = 1'b0;
      ctrl.mul_wr    = 1'b0;
      ctrl.fin       = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               pc_in    = entry_addr(opcode);
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            case (cw.uop)
               UOP_MUL: begin
                  ctrl.mul_start = 1'b1;
                  state_in       = SEQ_WAIT;
               end
               UOP_ADD, UOP_CLAMP, UOP_RAMP: begin
                  ctrl.exec = 1'b1;
                  pc_in     = pc_ff + 1'b1;
               end
               UOP_JNAW: pc_in = aw_enable ? pc_ff + 1'b1 : cw.target;
               UOP_FIN: begin
                  if (out_free) begin
                     ctrl.fin = 1'b1;
                     state_in = SEQ_IDLE;
                  end
               end
               default: state_in = SEQ_IDLE;
            endcase
         end
         SEQ_WAIT: begin
            if (mul_done) begin
               ctrl.mul_wr = 1'b1;
               pc_in       = pc_ff + 1'b1;
               state_in    = SEQ_RUN;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= UA_STEP;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   assign idle = (state_ff == SEQ_IDLE);

endmodule

`default_nettype wire

// File: sv/pid_step_ramp_antiwindup_core.sv
// Top level of the PID step core: configuration registers, datapath, output
// register, and the sequencer and multiplier instances.
// Depends on psra_pkg, psra_seq and psra_mul.
//
// Usage. A request on the req_ stream carries an opcode in req_tuser and an
// error sample (signed Q16.16) in req_tdata. Each request yields exactly one
// response on the rsp_ stream: the drive value in rsp_tdata and the at-limit
// flag in rsp_tuser. Opcode zero runs one controller step; opcode one clears
// the integral, previous error and previous output; opcode two clears only
// the integral. Clear requests, and the unused opcode, answer with zero.
// Gains, limit, ramp step and the anti-windup switch are written through the
// csr_ port, which is always ready and should be used only while idle.
// One request is worked on at a time. With the default widths, each
// multiplication is issued, built from two 32-bit partial products, saturated
// and written back on the one shared multiplier. Enabling anti-windup adds
// the back-calculation words to a step.
// Reset clears all controller state and returns every register to its reset
// value (limit to full scale). If the receiver stalls, the response is held
// in the output register; a new request is still accepted, but its final
// step waits until the register is free.
`default_nettype none

module pid_step_ramp_antiwindup_core import psra_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // bits up from 0: error (DATA_WIDTH), zero padding to whole bytes
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // bits up from 0: opcode (2)
   input  wire logic [OPCODE_WIDTH-1:0]              req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // bits up from 0: drive (DATA_WIDTH), zero padding to whole bytes
   output logic [((DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // bits up from 0: at_limit (1)
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]           csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]            csr_data
);

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int SUM_WIDTH   = DATA_WIDTH + 2;
   localparam int LIM_WIDTH   = (DATA_WIDTH > REG_WIDTH) ? DATA_WIDTH : REG_WIDTH;
   localparam int RAMP_WIDTH  = LIM_WIDTH + 2;

   localparam logic [LIM_WIDTH-1:0] SMAX_L = LIM_WIDTH'({(DATA_WIDTH-1){1'b1}});
   localparam logic signed [SUM_WIDTH-1:0] SMAX_S =
      SUM_WIDTH'({(DATA_WIDTH-1){1'b1}});
   localparam logic signed [SUM_WIDTH-1:0] NSMAX_S = -SMAX_S;
   localparam logic signed [RAMP_WIDTH-1:0] SMAX_R =
      RAMP_WIDTH'({(DATA_WIDTH-1){1'b1}});
   localparam logic signed [RAMP_WIDTH-1:0] NSMAX_R = -SMAX_R;

   // Configuration registers.
   logic [REG_WIDTH-1:0] kp_ff, ki_ff, kd_ff, inv_kp_ff, limit_ff, ramp_ff;
   logic                 aw_ff;

   // Controller state kept between steps.
   logic signed [DATA_WIDTH-1:0] integ_ff, integ_in;
   logic signed [DATA_WIDTH-1:0] perr_ff, perr_in;
   logic signed [DATA_WIDTH-1:0] pout_ff, pout_in;

   // Working registers of one step.
   logic signed [DATA_WIDTH-1:0] err_ff, err_in;
   logic signed [DATA_WIDTH-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic signed [DATA_WIDTH-1:0] s_ff, s_in, y_ff, y_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] drive_ff, drive_in;
   logic                         at_limit_ff, at_limit_in;

   psra_ctrl_type                ctrl;
   logic                         seq_idle;
   logic                         req_fire;
   logic                         out_free;
   logic                         mul_done;
   logic signed [DATA_WIDTH-1:0] mul_res;
   logic [REG_WIDTH-1:0]         gain_sel;

   logic signed [DATA_WIDTH-1:0] opa, opb;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic signed [DATA_WIDTH-1:0] add_res, clamp_res, ramp_res, alu_res, wr_val;
   logic [LIM_WIDTH-1:0]         lim_x, lim_sel;
   logic signed [DATA_WIDTH-1:0] lim, nlim;
   logic signed [RAMP_WIDTH-1:0] y_x, po_x, step_x, diff, up, dn;
   logic signed [RAMP_WIDTH-1:0] up_sat, dn_sat;
   logic                         hit;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = seq_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   psra_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .opcode    (req_tuser),
      .aw_enable (aw_ff),
      .mul_done  (mul_done),
      .out_free  (out_free),
      .idle      (seq_idle),
      .ctrl      (ctrl)
   );

   psra_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.mul_start),
      .operand (sum),
      .gain    (gain_sel),
      .done    (mul_done),
      .result  (mul_res)
   );

   // Operand selection for the shared adder, and gain selection for the multiplier.
   always_comb begin
      case (ctrl.cw.src_a)
         SRC_ERR:   opa = err_ff;
         SRC_PERR:  opa = perr_ff;
         SRC_INTEG: opa = integ_ff;
         SRC_P:     opa = p_ff;
         SRC_I:     opa = i_ff;
         SRC_D:     opa = d_ff;
         SRC_S:     opa = s_ff;
         SRC_Y:     opa = y_ff;
         default:   opa = '0;
      endcase
      case (ctrl.cw.src_b)
         SRC_ERR:   opb = err_ff;
         SRC_PERR:  opb = perr_ff;
         SRC_INTEG: opb = integ_ff;
         SRC_P:     opb = p_ff;
         SRC_I:     opb = i_ff;
         SRC_D:     opb = d_ff;
         SRC_S:     opb = s_ff;
         SRC_Y:     opb = y_ff;
         default:   opb = '0;
      endcase
      case (ctrl.cw.gain)
         GAIN_KP:     gain_sel = kp_ff;
         GAIN_KI:     gain_sel = ki_ff;
         GAIN_KD:     gain_sel = kd_ff;
         GAIN_INV_KP: gain_sel = inv_kp_ff;
         default:     gain_sel = kp_ff;
      endcase
   end

   // The adder also forms the unsaturated multiplier operand (e + e', e - e',
   // or the clamp excess), which may need one bit beyond the data range.
   always_comb begin
      sum = ctrl.cw.neg_b ? SUM_WIDTH'(opa) - SUM_WIDTH'(opb)
                          : SUM_WIDTH'(opa) + SUM_WIDTH'(opb);
      if (sum > SMAX_S) begin
         add_res = SMAX_S[DATA_WIDTH-1:0];
      end else if (sum < NSMAX_S) begin
         add_res = NSMAX_S[DATA_WIDTH-1:0];
      end else begin
         add_res = sum[DATA_WIDTH-1:0];
      end
   end

   // Effective limit is the register value capped at full scale; the clamp holds opa within it.
   always_comb begin
      lim_x   = LIM_WIDTH'(limit_ff);
      lim_sel = (lim_x > SMAX_L) ? SMAX_L : lim_x;
      lim     = lim_sel[DATA_WIDTH-1:0];
      nlim    = -lim;
      if (opa > lim) begin
         clamp_res = lim;
      end else if (opa < nlim) begin
         clamp_res = nlim;
      end else begin
         clamp_res = opa;
      end
   end

   // Ramp limiter: unless ramp_step is zero, hold the output within ramp_step
   // of the previous output, saturated only to the data range, not the limit.
   always_comb begin
      y_x    = RAMP_WIDTH'(opa);
      po_x   = RAMP_WIDTH'(pout_ff);
      step_x = RAMP_WIDTH'(ramp_ff);
      diff   = y_x - po_x;
      up     = po_x + step_x;
      dn     = po_x - step_x;
      up_sat = (up > SMAX_R) ? SMAX_R : up;
      dn_sat = (dn < NSMAX_R) ? NSMAX_R : dn;
      if (ramp_ff == '0) begin
         ramp_res = opa;
      end else if (diff > step_x) begin
         ramp_res = up_sat[DATA_WIDTH-1:0];
      end else if (diff < -step_x) begin
         ramp_res = dn_sat[DATA_WIDTH-1:0];
      end else begin
         ramp_res = opa;
      end
   end

   always_comb begin
      case (ctrl.cw.uop)
         UOP_ADD:   alu_res = add_res;
         UOP_CLAMP: alu_res = clamp_res;
         UOP_RAMP:  alu_res = ramp_res;
         default:   alu_res = add_res;
      endcase
      wr_val = ctrl.mul_wr ? mul_res : alu_res;
      hit    = (y_ff == lim) || (y_ff == nlim);
   end

   // Next values of the datapath and output register.
   always_comb begin
      err_in       = err_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      y_in         = y_ff;
      integ_in     = integ_ff;
      perr_in      = perr_ff;
      pout_in      = pout_ff;
      drive_in     = drive_ff;
      at_limit_in  = at_limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (req_fire) begin
         err_in = req_tdata[DATA_WIDTH-1:0];
      end

      if (ctrl.exec || ctrl.mul_wr) begin
         case (ctrl.cw.dst)
            DST_P:   p_in = wr_val;
            DST_I:   i_in = wr_val;
            DST_D:   d_in = wr_val;
            DST_S:   s_in = wr_val;
            DST_Y:   y_in = wr_val;
            default: y_in = wr_val;
         endcase
      end

      if (ctrl.fin) begin
         rsp_valid_in = 1'b1;
         drive_in     = '0;
         at_limit_in  = 1'b0;
         case (ctrl.cw.fin)
            FIN_STEP: begin
               // the integral is not kept while the output sits on a limit
               if (!hit) begin
                  integ_in = i_ff;
               end
               pout_in     = y_ff;
               perr_in     = err_ff;
               drive_in    = y_ff;
               at_limit_in = hit;
            end
            FIN_CLEAR_ALL: begin
               integ_in = '0;
               perr_in  = '0;
               pout_in  = '0;
            end
            FIN_CLEAR_INT: integ_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         inv_kp_ff    <= '0;
         limit_ff     <= '1;
         ramp_ff      <= '0;
         aw_ff        <= 1'b0;
         integ_ff     <= '0;
         perr_ff      <= '0;
         pout_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KP:          kp_ff     <= csr_data[REG_WIDTH-1:0];
               CSR_KI_HALF_TS:  ki_ff     <= csr_data[REG_WIDTH-1:0];
               CSR_KD_OVER_TS:  kd_ff     <= csr_data[REG_WIDTH-1:0];
               CSR_INV_KP:      inv_kp_ff <= csr_data[REG_WIDTH-1:0];
               CSR_LIMIT:       limit_ff  <= csr_data[REG_WIDTH-1:0];
               CSR_RAMP_STEP:   ramp_ff   <= csr_data[REG_WIDTH-1:0];
               CSR_ANTI_WINDUP: aw_ff     <= csr_data[0];
               default: ;
            endcase
         end
         integ_ff     <= integ_in;
         perr_ff      <= perr_in;
         pout_ff      <= pout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff      <= err_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      s_ff        <= s_in;
      y_ff        <= y_in;
      drive_ff    <= drive_in;
      at_limit_ff <= at_limit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'($unsigned(drive_ff));
   assign rsp_tuser  = at_limit_ff;

endmodule

`default_nettype wire

// File: sv/psra_checker.sv
// Port-level checker for the PID step core and the bind that attaches it.
// Depends on psra_pkg and pid_step_ramp_antiwindup_core.
`default_nettype none

module psra_checker import psra_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [((DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);

   // No response is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // Only one request is in flight at a time.
   a_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // Even a clear request needs a sequencer step before it answers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared in the cycle after acceptance");

   // A stalled response keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind pid_step_ramp_antiwindup_core psra_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_psra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: tb/sv/pid_step_ramp_antiwindup_core_tb.sv
// Self-checking testbench for the PID step core: directed requests, then random requests
// under several register settings, each response checked against a typed or predicted answer.
// Depends on psra_pkg and pid_step_ramp_antiwindup_core.
`default_nettype none

module pid_step_ramp_antiwindup_core_tb import psra_pkg::*;;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int BUS_W = ((DW + 7) / 8) * 8;
   localparam longint SMAX = (longint'(1) << (DW - 1)) - 1;
   localparam logic [REG_WIDTH-1:0] REG_MAX = {REG_WIDTH{1'b1}};

   // The fourth opcode has no meaning; the core must answer it with zero and keep its state.
   localparam logic [OPCODE_WIDTH-1:0] OPC_UNUSED = 2'd3;

   localparam int NROWS        = 42;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 60;
   localparam int STALL_LIMIT  = 2000;

   typedef struct {
      logic [DW-1:0] drive;
      logic          hit;
   } drive_result_type;

   // What the directed part knows in advance about one request.
   typedef struct {
      logic             typed;
      drive_result_type want;
   } preset_type;

   typedef struct {
      logic                    is_reg;
      csr_index_type           idx;
      logic [OPCODE_WIDTH-1:0] op;
      logic [31:0]             value;
      logic                    typed;
      logic [DW-1:0]           want_drive;
      logic                    want_hit;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [BUS_W-1:0]              req_tdata;
   logic [OPCODE_WIDTH-1:0]       req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [BUS_W-1:0]              rsp_tdata;
   logic                          rsp_tuser;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_data;

   // Private copy of the register file and controller state used for prediction.
   logic [REG_WIDTH-1:0] cfg_kp, cfg_ki, cfg_kd, cfg_inv_kp, cfg_limit, cfg_ramp;
   logic                 cfg_aw;
   longint               integ_acc, last_error, last_drive;

   drive_result_type drive_expect_q[$];
   preset_type       preset_q[$];
   script_row_type   script [NROWS];

   int  mismatches = 0;
   int  n_sent     = 0;
   int  n_done     = 0;
   int  hold_asks  = 0;
   int  holds_done = 0;
   int  stalled_cycles;
   bit  send_gaps  = 1'b1;
   bit  rsp_stalls = 1'b1;

   pid_step_ramp_antiwindup_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // bits up from 0: error (DW)
      .req_tuser  (req_tuser),   // bits up from 0: opcode (2)
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // bits up from 0: drive (DW)
      .rsp_tuser  (rsp_tuser),   // bits up from 0: at_limit (1)
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ------------------------------------------------------------------------------------
   // Fixed-point helpers. Every sum saturates to the symmetric data range, and every
   // product is formed exactly, its magnitude truncated by the fraction bits and then
   // saturated, so that rounding is always towards zero.
   // ------------------------------------------------------------------------------------
   function automatic longint sat_data(input longint v);
      if (v > SMAX) return SMAX;
      if (v < -SMAX) return -SMAX;
      return v;
   endfunction

   function automatic longint clamp_to(input longint v, input longint l);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
   endfunction

   function automatic longint scale_gain(input longint a, input logic [REG_WIDTH-1:0] g);
      logic [63:0] mag;
      logic [95:0] prod;
      mag  = (a < 0) ? 64'(-a) : 64'(a);
      prod = (96'(mag) * 96'(g)) >> FB;
      if (prod > 96'(SMAX)) prod = 96'(SMAX);
      return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic void reset_model();
      cfg_kp     = '0;
      cfg_ki     = '0;
      cfg_kd     = '0;
      cfg_inv_kp = '0;
      cfg_limit  = REG_MAX;
      cfg_ramp   = '0;
      cfg_aw     = 1'b0;
      integ_acc  = 0;
      last_error = 0;
      last_drive = 0;
   endfunction

   // Works out the response to one accepted request and advances the controller state.
   function automatic drive_result_type predict_drive(input logic [OPCODE_WIDTH-1:0] op,
                                                      input logic [DW-1:0] err);
      drive_result_type res;
      longint e, lim, p, i, d, s, y, ramp;
      res.drive = '0;
      res.hit   = 1'b0;
      case (op)
         OPC_CLEAR_ALL: begin
            integ_acc  = 0;
            last_error = 0;
            last_drive = 0;
         end
         OPC_CLEAR_INT: integ_acc = 0;
         OPC_STEP: begin
            e   = longint'($signed(err));
            lim = (longint'(cfg_limit) > SMAX) ? SMAX : longint'(cfg_limit);
            p   = scale_gain(e, cfg_kp);
            i   = sat_data(integ_acc + scale_gain(e + last_error, cfg_ki));
            d   = scale_gain(e - last_error, cfg_kd);
            // Back-calculation takes its excess from the saturated, unclamped sum.
            if (cfg_aw) begin
               s = sat_data(sat_data(p + i) + d);
               i = sat_data(i + scale_gain(clamp_to(s, lim) - s, cfg_inv_kp));
            end
            i = clamp_to(i, lim);
            y = clamp_to(sat_data(sat_data(p + i) + d), lim);
            // The ramp works from the previous output and so may leave a lowered limit.
            if (cfg_ramp != '0) begin
               ramp = longint'(cfg_ramp);
               if (y - last_drive > ramp) y = sat_data(last_drive + ramp);
               else if (y - last_drive < -ramp) y = sat_data(last_drive - ramp);
            end
            res.hit = (y == lim) || (y == -lim);
            if (!res.hit) integ_acc = i;
            last_drive = y;
            last_error = e;
            res.drive  = DW'(y);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [CSR_DATA_WIDTH-1:0] val);
      case (idx)
         CSR_KP:          cfg_kp     = val[REG_WIDTH-1:0];
         CSR_KI_HALF_TS:  cfg_ki     = val[REG_WIDTH-1:0];
         CSR_KD_OVER_TS:  cfg_kd     = val[REG_WIDTH-1:0];
         CSR_INV_KP:      cfg_inv_kp = val[REG_WIDTH-1:0];
         CSR_LIMIT:       cfg_limit  = val[REG_WIDTH-1:0];
         CSR_RAMP_STEP:   cfg_ramp   = val[REG_WIDTH-1:0];
         CSR_ANTI_WINDUP: cfg_aw     = val[0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      $display("%0t: %s on response %0d: got %h, expected %h",
               $time, what, n_done, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the nonblocking updates of
   // that edge, so each handshake is seen exactly as the core saw it. Responses are
   // checked before new requests are predicted; the two never belong to the same request.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      drive_result_type want, got;
      preset_type       pre;
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_done++;
            got.drive = rsp_tdata[DW-1:0];
            got.hit   = rsp_tuser;
            if (drive_expect_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", got.drive, '0);
            end else begin
               want = drive_expect_q.pop_front();
               if (got.drive !== want.drive)
                  report_mismatch("drive mismatch", got.drive, want.drive);
               if (got.hit !== want.hit)
                  report_mismatch("at_limit mismatch", DW'(got.hit), DW'(want.hit));
            end
         end
         if (req_tvalid && req_tready) begin
            pre  = preset_q.pop_front();
            want = predict_drive(req_tuser, req_tdata[DW-1:0]);
            // Rows with a typed answer still advance the predictor so that its state stays
            // in step with the core for the rows that follow.
            drive_expect_q.push_back(pre.typed ? pre.want : want);
         end
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
      end
   end

   // The watchdog ends the run when no request, response or register write has been
   // accepted for a long stretch; the longest legitimate gap is the deliberate hold below.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------------------
   // Response side. Stalls come in random bursts while enabled. When the sender asks for
   // it, the receiver refuses responses for a long stretch so that the core's output
   // register fills and it stops taking requests.
   // ------------------------------------------------------------------------------------
   initial begin : receiver
      int held;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asks != holds_done) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            holds_done++;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------------------
   task automatic send_request(input logic [OPCODE_WIDTH-1:0] op, input logic [DW-1:0] err,
                               input logic typed, input logic [DW-1:0] want_drive,
                               input logic want_hit);
      preset_q.push_back('{typed, '{want_drive, want_hit}});
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= BUS_W'(err);
      do @(posedge clock); while (!req_tready);
      n_sent++;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every outstanding response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (n_done < n_sent) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Gains are mostly moderate so that steps land inside the limit as often as on it.
   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1:       return 32'(REG_MAX);
         2:       return $urandom();
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   task automatic program_phase(input bit tame);
      logic [31:0] lim, ramp;
      if (!tame && $urandom_range(0, 7) == 0) lim = 32'h0;
      else if (!tame && $urandom_range(0, 7) == 0) lim = 32'(REG_MAX);
      else lim = $urandom_range(1, 32'h00C8_0000);
      ramp = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom_range(1, 32'h0010_0000);
      write_reg(CSR_KP, pick_gain());
      write_reg(CSR_KI_HALF_TS, pick_gain());
      write_reg(CSR_KD_OVER_TS, pick_gain());
      write_reg(CSR_INV_KP, pick_gain());
      write_reg(CSR_LIMIT, lim);
      write_reg(CSR_RAMP_STEP, ramp);
      write_reg(CSR_ANTI_WINDUP, $urandom());
   endtask

   // Mostly small errors so the integral builds up gradually; some full-range values and
   // some exact extremes to reach the saturation paths.
   function automatic logic [DW-1:0] pick_error();
      case ($urandom_range(0, 9))
         0:       return DW'($urandom());
         1:       return ($urandom_range(0, 1) == 0) ? DW'(SMAX) : DW'(-SMAX - 1);
         default: return DW'($urandom_range(0, 32'h0040_0000)) - DW'(32'h0020_0000);
      endcase
   endfunction

   function automatic logic [OPCODE_WIDTH-1:0] pick_opcode();
      case ($urandom_range(0, 19))
         0:       return OPC_CLEAR_ALL;
         1:       return OPC_CLEAR_INT;
         2:       return OPC_UNUSED;
         default: return OPC_STEP;
      endcase
   endfunction

   initial begin : stimulus
      int             r, ph, k;
      script_row_type row;

      // Directed part. Answers are typed in only where they follow at once: with all gains
      // zero the output is zero, clears and the unused opcode answer zero, and a zero limit
      // without a ramp pins the output to zero with the limit flag raised.
      script = '{
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b1, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_CLEAR_ALL, 32'h0,         1'b1, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_UNUSED,    32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_CLEAR_INT, 32'h1234_5678, 1'b1, 32'h0, 1'b0},
         '{1'b1, CSR_KP,          OPC_STEP, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_KI_HALF_TS,  OPC_STEP, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_KD_OVER_TS,  OPC_STEP, 32'h0000_1000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_LIMIT,       OPC_STEP, 32'h0064_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h0001_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h0003_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_CLEAR_INT, 32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_ANTI_WINDUP, OPC_STEP, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_INV_KP,      OPC_STEP, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_RAMP_STEP,   OPC_STEP, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
         // Limit lowered below the previous output while the ramp is active.
         '{1'b1, CSR_LIMIT,       OPC_STEP, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_UNUSED,    32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_RAMP_STEP,   OPC_STEP, 32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_LIMIT,       OPC_STEP, 32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h1234_5678, 1'b1, 32'h0, 1'b1},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b1, 32'h0, 1'b1},
         '{1'b0, CSR_KP, OPC_CLEAR_ALL, 32'h0,         1'b1, 32'h0, 1'b0},
         // Every register at full scale.
         '{1'b1, CSR_KP,          OPC_STEP, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_KI_HALF_TS,  OPC_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_KD_OVER_TS,  OPC_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_INV_KP,      OPC_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_LIMIT,       OPC_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_RAMP_STEP,   OPC_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{1'b1, CSR_ANTI_WINDUP, OPC_STEP, 32'h0,         1'b0, 32'h0, 1'b0},
         '{1'b0, CSR_KP, OPC_STEP,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0}
      };

      // Every input is at a known level from time zero, with reset asserted.
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OPC_STEP;
      csr_valid  = 1'b0;
      csr_index  = CSR_KP;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register writes only ever happen with the core idle.
      for (r = 0; r < NROWS; r++) begin
         row = script[r];
         if (row.is_reg) begin
            drain_responses();
            write_reg(row.idx, row.value);
         end else begin
            send_request(row.op, row.value[DW-1:0], row.typed, row.want_drive, row.want_hit);
         end
      end

      // Random part: a fresh register setting per phase. Idling is switched on and off in
      // stretches, and the last phase runs with no idling on either side.
      for (ph = 0; ph < PHASES; ph++) begin
         drain_responses();
         program_phase(ph == PHASES - 1);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 50 == 0) begin
               send_gaps  = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
               rsp_stalls = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
            end
            // Long hold on the response side while requests keep coming.
            if (ph == 1 && k == 40) hold_asks++;
            // Once, the sender stops until every outstanding response has returned.
            if (ph == 2 && k == 75) drain_responses();
            send_request(pick_opcode(), pick_error(), 1'b0, '0, 1'b0);
         end
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && drive_expect_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
